/* rtl/adti_pkg.sv */
// Shared types, widths and the calibration ROM contents for the ADC to temperature block.
// No dependencies.
`default_nettype none

package adti_pkg;

    localparam int CODE_W      = 12;  // ADC code width
    localparam int TEMP_W      = 13;  // output temperature width
    localparam int ROM_ENTRIES = 15;  // entries per calibration table
    localparam int IDX_W       = 4;   // index into one table
    localparam int DEG_W       = 4;   // integer degree magnitude, 0..ROM_ENTRIES-1

    typedef logic [CODE_W-1:0] t_code;

    typedef struct packed {
        logic             neg;   // 1: falling (negative degree) table
        logic [IDX_W-1:0] idx;
    } t_rom_addr;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV
    } t_state;

    // Calibration points: entry i marks i degrees of magnitude.
    function automatic t_code rom_value(input logic neg, input logic [IDX_W-1:0] idx);
        t_code v;
        unique case ({neg, idx})
            5'h00: v = 12'd963;
            5'h01: v = 12'd1001;
            5'h02: v = 12'd1040;
            5'h03: v = 12'd1079;
            5'h04: v = 12'd1120;
            5'h05: v = 12'd1161;
            5'h06: v = 12'd1202;
            5'h07: v = 12'd1244;
            5'h08: v = 12'd1287;
            5'h09: v = 12'd1330;
            5'h0A: v = 12'd1374;
            5'h0B: v = 12'd1418;
            5'h0C: v = 12'd1462;
            5'h0D: v = 12'd1507;
            5'h0E: v = 12'd1552;
            5'h10: v = 12'd963;
            5'h11: v = 12'd926;
            5'h12: v = 12'd889;
            5'h13: v = 12'd854;
            5'h14: v = 12'd819;
            5'h15: v = 12'd785;
            5'h16: v = 12'd752;
            5'h17: v = 12'd720;
            5'h18: v = 12'd688;
            5'h19: v = 12'd658;
            5'h1A: v = 12'd629;
            5'h1B: v = 12'd600;
            5'h1C: v = 12'd572;
            5'h1D: v = 12'd546;
            5'h1E: v = 12'd520;
            default: v = '0;  // unused slot past the last entry
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/adc_to_temperature_interpolator_top.sv */
// ADC code to temperature converter: table scan over the calibration ROM,
// then a bit-serial divide for the interpolation fraction. Uses adti_pkg, adti_rom.
`default_nettype none

// Usage
//   Input: drive i_adc_code and raise start; a beat is taken on a clock edge
//   with start high and busy low. busy stays high while the code is worked on.
//   Output: o_valid is high for exactly one cycle with o_temp_q8 (signed,
//   FRAC_BITS fraction bits) and o_clamped. The receiver cannot stall; a
//   result is shown once and is gone the next cycle.
//   Work done from the accepting edge until o_valid is high:
//     - code outside the table range: no scan, busy never rises, so a new
//       beat can be taken on the very next edge;
//     - code equal to table entry j: scan of entries 0..j;
//     - code inside segment (j-1, j): scan of entries 0..j, then the divide.
//   The ROM is scanned one entry per cycle (single read port, registered read
//   data, next address issued while the current entry is compared), and
//   the fraction takes one quotient bit per cycle; busy falls as o_valid rises.
//   Reset (i_rst_n low, synchronous) returns the sequencer to idle and drops
//   o_valid; the datapath and output data registers are not reset.
module adc_to_temperature_interpolator_top #(
    parameter int TABLE_ENTRIES = 15,
    parameter int FRAC_BITS     = 8
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   start,
    input  wire logic [adti_pkg::CODE_W-1:0]            i_adc_code,
    output      logic                                   busy,
    output      logic                                   o_valid,
    output      logic signed [adti_pkg::TEMP_W-1:0]     o_temp_q8,
    output      logic                                   o_clamped
);

    localparam int CODE_W = adti_pkg::CODE_W;
    localparam int TEMP_W = adti_pkg::TEMP_W;
    localparam int IDX_W  = adti_pkg::IDX_W;
    localparam int DEG_W  = adti_pkg::DEG_W;

    // Entries actually in use: the ROM holds ROM_ENTRIES, at least two are needed.
    localparam int N_USE = (TABLE_ENTRIES > adti_pkg::ROM_ENTRIES) ? adti_pkg::ROM_ENTRIES :
                           (TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_USE - 1);
    localparam logic [DEG_W-1:0] LAST_DEG = DEG_W'(N_USE - 1);

    localparam adti_pkg::t_code POS_TOP = adti_pkg::rom_value(1'b0, LAST_IDX);
    localparam adti_pkg::t_code NEG_TOP = adti_pkg::rom_value(1'b1, LAST_IDX);
    localparam adti_pkg::t_code CENTER  = adti_pkg::rom_value(1'b1, '0);

    localparam int CNT_W = $clog2(FRAC_BITS);
    localparam int MAG_W = DEG_W + FRAC_BITS;
    localparam int EXT_W = (MAG_W > TEMP_W) ? MAG_W : TEMP_W;

    // Magnitude is {degree, fraction}; negate on the cold side, wrap to the port width.
    function automatic logic [TEMP_W-1:0] form_temp(input logic             neg,
                                                     input logic [DEG_W-1:0] deg,
                                                     input logic [FRAC_BITS-1:0] frac);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'({deg, frac});
        if (neg) begin
            ext = -ext;
        end
        return ext[TEMP_W-1:0];
    endfunction

    adti_pkg::t_state r_state, n_state;

    adti_pkg::t_code        r_code,  n_code;
    logic                   r_neg,   n_neg;
    logic [IDX_W-1:0]       r_idx,   n_idx;     // index of entry now on the ROM output
    adti_pkg::t_code        r_prev,  n_prev;    // previous entry of the scan
    logic [CODE_W-1:0]      r_rem,   n_rem;     // divider remainder, always below span
    adti_pkg::t_code        r_span,  n_span;
    logic [FRAC_BITS-1:0]   r_quo,   n_quo;
    logic [DEG_W-1:0]       r_deg,   n_deg;
    logic [CNT_W-1:0]       r_cnt,   n_cnt;
    logic                   r_valid, n_valid;
    logic [TEMP_W-1:0]      r_temp,  n_temp;
    logic                   r_clamp, n_clamp;

    adti_pkg::t_rom_addr rom_addr;
    adti_pkg::t_code     rom_data;

    adti_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    // Input classification
    logic in_hi, in_lo, in_neg, accept;
    assign accept = start && (r_state == adti_pkg::ST_IDLE);
    assign in_hi  = i_adc_code > POS_TOP;
    assign in_lo  = i_adc_code < NEG_TOP;
    assign in_neg = i_adc_code <= CENTER;

    // Scan compare against the entry on the ROM output
    logic              hit_eq, hit_pass;
    adti_pkg::t_code   seg_off, seg_span;
    assign hit_eq   = r_code == rom_data;
    assign hit_pass = r_neg ? (r_code > rom_data) : (r_code < rom_data);
    assign seg_off  = r_neg ? (r_prev - r_code) : (r_code - r_prev);
    assign seg_span = r_neg ? (r_prev - rom_data) : (rom_data - r_prev);

    // Restoring divide step
    logic [CODE_W:0] div_shift;
    logic            div_ge, div_last;
    assign div_shift = {r_rem, 1'b0};
    assign div_ge    = div_shift >= {1'b0, r_span};
    assign div_last  = r_cnt == CNT_W'(FRAC_BITS - 1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            adti_pkg::ST_IDLE: begin
                if (accept && !in_hi && !in_lo) begin
                    n_state = adti_pkg::ST_SCAN;
                end
            end
            adti_pkg::ST_SCAN: begin
                priority if (hit_eq) begin
                    n_state = adti_pkg::ST_IDLE;
                end else if (hit_pass) begin
                    n_state = adti_pkg::ST_DIV;
                end else begin
                    n_state = adti_pkg::ST_SCAN;
                end
            end
            adti_pkg::ST_DIV: begin
                if (div_last) begin
                    n_state = adti_pkg::ST_IDLE;
                end
            end
            default: n_state = adti_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_code  = r_code;
        n_neg   = r_neg;
        n_idx   = r_idx;
        n_prev  = r_prev;
        n_rem   = r_rem;
        n_span  = r_span;
        n_quo   = r_quo;
        n_deg   = r_deg;
        n_cnt   = r_cnt;
        n_valid = 1'b0;
        n_temp  = r_temp;
        n_clamp = r_clamp;
        rom_addr.neg = r_neg;
        rom_addr.idx = r_idx + 1'b1;  // prefetch the next entry

        unique case (r_state)
            adti_pkg::ST_IDLE: begin
                rom_addr.neg = in_neg;
                rom_addr.idx = '0;
                if (accept) begin
                    n_code = i_adc_code;
                    n_neg  = in_neg;
                    n_idx  = '0;
                    if (in_hi || in_lo) begin
                        n_valid = 1'b1;
                        n_clamp = 1'b1;
                        n_temp  = form_temp(in_lo, LAST_DEG, '0);
                    end
                end
            end
            adti_pkg::ST_SCAN: begin
                priority if (hit_eq) begin
                    n_valid = 1'b1;
                    n_clamp = 1'b0;
                    n_temp  = form_temp(r_neg, r_idx, '0);
                end else if (hit_pass) begin
                    n_rem  = seg_off;
                    n_span = seg_span;
                    n_deg  = r_idx - 1'b1;
                    n_cnt  = '0;
                    n_quo  = '0;
                end else begin
                    n_prev = rom_data;
                    n_idx  = r_idx + 1'b1;
                end
            end
            adti_pkg::ST_DIV: begin
                n_rem = div_ge ? CODE_W'(div_shift - {1'b0, r_span}) : div_shift[CODE_W-1:0];
                n_quo = {r_quo[FRAC_BITS-2:0], div_ge};
                n_cnt = r_cnt + 1'b1;
                if (div_last) begin
                    n_valid = 1'b1;
                    n_clamp = 1'b0;
                    n_temp  = form_temp(r_neg, r_deg, n_quo);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= adti_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code  <= n_code;
        r_neg   <= n_neg;
        r_idx   <= n_idx;
        r_prev  <= n_prev;
        r_rem   <= n_rem;
        r_span  <= n_span;
        r_quo   <= n_quo;
        r_deg   <= n_deg;
        r_cnt   <= n_cnt;
        r_temp  <= n_temp;
        r_clamp <= n_clamp;
    end

    assign busy      = r_state != adti_pkg::ST_IDLE;
    assign o_valid   = r_valid;
    assign o_temp_q8 = signed'(r_temp);
    assign o_clamped = r_clamp;

endmodule

`default_nettype wire

/* rtl/adti_rom.sv */
// Calibration ROM with registered read data.
// Depends on adti_pkg.
`default_nettype none

module adti_rom (
    input  wire logic               i_clk,
    input  wire adti_pkg::t_rom_addr i_addr,
    output      adti_pkg::t_code     o_data
);

    adti_pkg::t_code r_data;

    always_ff @(posedge i_clk) begin
        r_data <= adti_pkg::rom_value(i_addr.neg, i_addr.idx);
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

/* rtl/adti_checker.sv */
// Port-level checks for the ADC to temperature block, bound to its top level.
// Depends on adc_to_temperature_interpolator_top.
`default_nettype none

module adti_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                start,
    input wire logic                                busy,
    input wire logic                                o_valid,
    input wire logic                                o_clamped
);

    // Reset leaves the block idle with no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_valid))
        else $error("block not idle after reset");

    // An accepted beat either starts work or answers at once.
    a_accept_acts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted beat produced no activity");

    // A result only follows an accept or a busy period, never out of nothing.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) || $past(start)))
        else $error("result without a beat");

    // The end of work always delivers its result, and results show while idle.
    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> (o_valid && !o_clamped))
        else $error("busy fell without a result");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

endmodule

bind adc_to_temperature_interpolator_top adti_checker u_adti_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_valid    (o_valid),
    .o_clamped  (o_clamped)
);

`default_nettype wire
